// ===== rtl/core/bced_pkg.sv =====
// Shared types and constants of the button click event detector.
// Used by the top, bced_update and bced_out; depends on nothing else.
package bced_pkg;

  localparam int ChipsDef    = 3;
  localparam int ChannelsDef = 16;

  localparam logic [3:0]  DebounceRst  = 4'd3;
  localparam logic [15:0] LongPressRst = 16'd800;
  localparam logic [15:0] ClickMaxRst  = 16'd300;
  localparam logic [15:0] DoubleGapRst = 16'd300;

  localparam int CfgDataW = 16;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_LONG    = 3'd1,
    EV_RELEASE = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_CLICK   = 3'd4
  } ev_code_e;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_CLICK_MAX  = 2'd2,
    CFG_DOUBLE_GAP = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  debounce;
    logic [15:0] long_ms;
    logic [15:0] click_ms;
    logic [15:0] gap_ms;
  } cfg_t;

  // One channel record as held in the state memory.
  typedef struct packed {
    logic        lvl;
    logic [3:0]  cnt;
    logic        act;
    logic        long_sent;
    logic [31:0] press_start;
    logic        pend;
    logic [31:0] click_time;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  // Events raised by one sample, in order of delivery.
  typedef struct packed {
    logic     v0;
    logic     v1;
    ev_code_e c0;
    ev_code_e c1;
  } ev_t;

endpackage

// ===== rtl/core/button_click_event_detector_top.sv =====
// Top level of the button click event detector.
// Depends on bced_pkg, bced_ram, bced_update and bced_out.

// Takes one raw button sample per item and raises press, long press, release,
// double and click events for its channel. A sample item is accepted in every
// cycle while the result side keeps up: the channel record is read from the
// state memory in the cycle of acceptance, updated in the next cycle and
// written back once the output register can take its events, with the record
// just written forwarded to a following sample of the same channel. Each
// sample gives zero, one or two event items, delivered one per cycle from the
// output register while the sink is ready; a sample with two events holds the
// input until its first event is taken. Samples whose chip or channel is out
// of range are accepted and dropped. After reset every record reads as
// cleared at once through per-channel valid bits; there is no clearing pass.
// Users must write registers only while the block is idle; it does not check.
module button_click_event_detector_top import bced_pkg::*; #(
  parameter int Chips    = ChipsDef,
  parameter int Channels = ChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // chip_index[1:0], channel_index[5:2], pressed[6], now_ms[38:7], zero pad
  input  logic [39:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // event_chip[1:0], event_channel[5:2], event_code[8:6], level[9], zero pad
  output logic [15:0]         m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Slots = Chips * Channels;
  localparam int AddrW = (Slots > 1) ? $clog2(Slots) : 1;

  cfg_t cfg_q;

  logic [1:0]  in_chip;
  logic [3:0]  in_chan;
  logic        in_pressed;
  logic [31:0] in_now;
  logic        in_range;
  logic [AddrW-1:0] in_addr;
  logic        accept;
  logic        fire;
  logic        out_free;

  logic             b_valid_q, b_valid_d;
  logic [AddrW-1:0] b_addr_q;
  logic [1:0]       b_chip_q;
  logic [3:0]       b_chan_q;
  logic             b_pressed_q;
  logic [31:0]      b_now_q;
  logic             hit_q;
  logic             vld_rd_q;
  rec_t             fwd_q;

  logic [Slots-1:0] valid_q;
  logic [RecW-1:0]  ram_rdata;
  rec_t             rec_cur;
  rec_t             rec_new;
  ev_t              ev;

  assign in_chip    = s_axis_tdata[1:0];
  assign in_chan    = s_axis_tdata[5:2];
  assign in_pressed = s_axis_tdata[6];
  assign in_now     = s_axis_tdata[38:7];
  assign in_range   = (32'(in_chip) < Chips) && (32'(in_chan) < Channels);
  assign in_addr    = AddrW'(32'(in_chip) * Channels + 32'(in_chan));

  assign fire          = b_valid_q && out_free;
  assign s_axis_tready = !b_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready && in_range;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= DebounceRst;
      cfg_q.long_ms  <= LongPressRst;
      cfg_q.click_ms <= ClickMaxRst;
      cfg_q.gap_ms   <= DoubleGapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:   cfg_q.debounce <= cfg_data_i[3:0];
        CFG_LONG_PRESS: cfg_q.long_ms  <= cfg_data_i;
        CFG_CLICK_MAX:  cfg_q.click_ms <= cfg_data_i;
        CFG_DOUBLE_GAP: cfg_q.gap_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bced_ram #(
    .Width (RecW),
    .Depth (Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (b_addr_q),
    .wdata_i (rec_new),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    b_valid_d = b_valid_q;
    if (accept) begin
      b_valid_d = 1'b1;
    end else if (fire) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      b_valid_q <= b_valid_d;
      if (fire) begin
        valid_q[b_addr_q] <= 1'b1;
      end
    end
  end

  // The memory returns the old record when the same channel is written in
  // the cycle of its read, so that case takes the written record instead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_addr_q    <= in_addr;
      b_chip_q    <= in_chip;
      b_chan_q    <= in_chan;
      b_pressed_q <= in_pressed;
      b_now_q     <= in_now;
      hit_q       <= fire && (b_addr_q == in_addr);
      vld_rd_q    <= valid_q[in_addr];
    end
    if (fire) begin
      fwd_q <= rec_new;
    end
  end

  always_comb begin
    if (hit_q) begin
      rec_cur = fwd_q;
    end else if (vld_rd_q) begin
      rec_cur = rec_t'(ram_rdata);
    end else begin
      rec_cur = '0;
    end
  end

  bced_update u_update (
    .rec_i     (rec_cur),
    .pressed_i (b_pressed_q),
    .now_i     (b_now_q),
    .cfg_i     (cfg_q),
    .rec_o     (rec_new),
    .ev_o      (ev)
  );

  bced_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .ev_i          (ev),
    .chip_i        (b_chip_q),
    .chan_i        (b_chan_q),
    .lvl_i         (rec_new.lvl),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/bced_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; holds the channel records of the detector.
module bced_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bced_update.sv =====
// Record update of one channel: debounce, press tracking and event decision.
// Depends on bced_pkg for the record, configuration and event types.
module bced_update import bced_pkg::*; (
  input  rec_t        rec_i,
  input  logic        pressed_i,
  input  logic [31:0] now_i,
  input  cfg_t        cfg_i,
  output rec_t        rec_o,
  output ev_t         ev_o
);

  localparam ev_code_e EvOrder [5] = '{EV_PRESS, EV_LONG, EV_RELEASE, EV_DOUBLE, EV_CLICK};

  logic        agree;
  logic [3:0]  cnt_inc;
  logic        flip;
  logic        cur;
  logic        ev_press, ev_long, ev_rel, ev_dbl, ev_click;
  logic [31:0] held;
  logic [31:0] since_click;
  logic [15:0] long_thr;
  logic        long_sent_n;
  logic        short_press;
  logic        in_gap;
  logic [4:0]  flags;

  always_comb begin
    agree   = (pressed_i == rec_i.lvl);
    cnt_inc = rec_i.cnt + 4'd1;
    flip    = !agree && (cnt_inc >= cfg_i.debounce);
    cur     = flip ? pressed_i : rec_i.lvl;

    held        = now_i - rec_i.press_start;
    since_click = now_i - rec_i.click_time;
    long_thr    = (cfg_i.long_ms == 16'd0) ? 16'd1 : cfg_i.long_ms;
    in_gap      = (since_click <= {16'd0, cfg_i.gap_ms});

    // A fresh press is not yet active, so it never raises a long press as well.
    ev_press    = cur && !rec_i.act;
    ev_long     = rec_i.act && !rec_i.long_sent && (held >= {16'd0, long_thr});
    long_sent_n = ev_press ? 1'b0 : (rec_i.long_sent | ev_long);
    ev_rel      = !cur && rec_i.act;
    short_press = !long_sent_n && (held <= {16'd0, cfg_i.click_ms});
    ev_dbl      = ev_rel && short_press && rec_i.pend && in_gap;
    // A release either leaves no pending click or one stamped with the current time.
    ev_click    = !ev_rel && rec_i.pend && !in_gap && !(ev_press && ev_long);

    rec_o.lvl         = cur;
    rec_o.cnt         = (agree || flip) ? 4'd0 : cnt_inc;
    rec_o.act         = ev_rel ? 1'b0 : (rec_i.act | ev_press);
    rec_o.long_sent   = long_sent_n;
    rec_o.press_start = ev_press ? now_i : rec_i.press_start;
    if (ev_rel) begin
      if (short_press && !(rec_i.pend && in_gap)) begin
        rec_o.pend       = 1'b1;
        rec_o.click_time = now_i;
      end else begin
        rec_o.pend       = 1'b0;
        rec_o.click_time = 32'd0;
      end
    end else if (ev_click) begin
      rec_o.pend       = 1'b0;
      rec_o.click_time = 32'd0;
    end else begin
      rec_o.pend       = rec_i.pend;
      rec_o.click_time = rec_i.click_time;
    end

    flags = {ev_click, ev_dbl, ev_rel, ev_long, ev_press};
    ev_o  = '{v0: 1'b0, v1: 1'b0, c0: EV_PRESS, c1: EV_PRESS};
    for (int k = 0; k < 5; k++) begin
      if (flags[k]) begin
        if (!ev_o.v0) begin
          ev_o.v0 = 1'b1;
          ev_o.c0 = EvOrder[k];
        end else if (!ev_o.v1) begin
          ev_o.v1 = 1'b1;
          ev_o.c1 = EvOrder[k];
        end
      end
    end
  end

endmodule

// ===== rtl/core/bced_out.sv =====
// Output register of the detector: holds the events of one sample and hands
// them out one item at a time. Depends on bced_pkg.
module bced_out import bced_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ev_t         ev_i,
  input  logic [1:0]  chip_i,
  input  logic [3:0]  chan_i,
  input  logic        lvl_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [1:0] cnt_q, cnt_d;
  ev_code_e   code0_q, code0_d;
  ev_code_e   code1_q, code1_d;
  logic [1:0] chip_q, chip_d;
  logic [3:0] chan_q, chan_d;
  logic       lvl_q, lvl_d;
  logic       take;

  assign take   = m_axis_tvalid && m_axis_tready;
  assign free_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);

  always_comb begin
    cnt_d   = cnt_q;
    code0_d = code0_q;
    code1_d = code1_q;
    chip_d  = chip_q;
    chan_d  = chan_q;
    lvl_d   = lvl_q;
    if (load_i && ev_i.v0) begin
      cnt_d   = ev_i.v1 ? 2'd2 : 2'd1;
      code0_d = ev_i.c0;
      code1_d = ev_i.c1;
      chip_d  = chip_i;
      chan_d  = chan_i;
      lvl_d   = lvl_i;
    end else if (take) begin
      if (cnt_q == 2'd2) begin
        cnt_d   = 2'd1;
        code0_d = code1_q;
      end else begin
        cnt_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code0_q <= code0_d;
    code1_q <= code1_d;
    chip_q  <= chip_d;
    chan_q  <= chan_d;
    lvl_q   <= lvl_d;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tlast  = (cnt_q == 2'd1);
  assign m_axis_tdata  = {6'd0, lvl_q, code0_q, chan_q, chip_q};

endmodule
